>>> hdl/abtmf_pkg.sv
// ----------------------------------------------------------------------------
// abtmf_pkg
// shared widths, trim window constants and sequencer states for the
// adc burst trimmed-mean filter
// ----------------------------------------------------------------------------
package abtmf_pkg;

   // fixed field widths of the channel words
   localparam int CHAN_W        = 4;
   localparam int SAMPLE_W      = 12;
   localparam int VALUE_W       = 12;
   localparam int SAMPLE_FIELDS = 10;

   // sorted positions kept by the trim: TRIM_FIRST up to TRIM_END - 1
   localparam int TRIM_FIRST = 3;
   localparam int TRIM_END   = 8;
   localparam int TRIM_COUNT = TRIM_END - TRIM_FIRST;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK,
      ST_SUM,
      ST_TRIM_DIV,
      ST_RING,
      ST_AVG_DIV,
      ST_OUT
   } abtmf_state_type;

endpackage

>>> hdl/abtmf_ifs.sv
// ----------------------------------------------------------------------------
// abtmf channel interfaces
// valid/ready channels for burst words and filtered result words
// ----------------------------------------------------------------------------
interface abtmf_req_if import abtmf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   channel;
   logic [SAMPLE_W-1:0] sample_0;
   logic [SAMPLE_W-1:0] sample_1;
   logic [SAMPLE_W-1:0] sample_2;
   logic [SAMPLE_W-1:0] sample_3;
   logic [SAMPLE_W-1:0] sample_4;
   logic [SAMPLE_W-1:0] sample_5;
   logic [SAMPLE_W-1:0] sample_6;
   logic [SAMPLE_W-1:0] sample_7;
   logic [SAMPLE_W-1:0] sample_8;
   logic [SAMPLE_W-1:0] sample_9;

   modport source (
      output valid, channel, sample_0, sample_1, sample_2, sample_3, sample_4,
             sample_5, sample_6, sample_7, sample_8, sample_9,
      input  ready
   );
   modport sink (
      input  valid, channel, sample_0, sample_1, sample_2, sample_3, sample_4,
             sample_5, sample_6, sample_7, sample_8, sample_9,
      output ready
   );
endinterface

interface abtmf_rsp_if import abtmf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CHAN_W-1:0]  out_channel;
   logic [VALUE_W-1:0] filtered_value;

   modport source (
      output valid, out_channel, filtered_value,
      input  ready
   );
   modport sink (
      input  valid, out_channel, filtered_value,
      output ready
   );
endinterface

>>> hdl/abtmf_rank_lane.sv
// ----------------------------------------------------------------------------
// abtmf_rank_lane
// one lane: ranks its own sample against the burst and flags it when the
// rank falls inside the trim window
// ----------------------------------------------------------------------------
module abtmf_rank_lane import abtmf_pkg::*; #(
   parameter int LANES    = 10,
   parameter int LANE_IDX = 0,
   parameter int DW       = 12
) (
   input  logic [LANES-1:0][DW-1:0] burst,
   output logic                     keep
);

   localparam int RW = $clog2(LANES + 1);

   logic [LANES-1:0] below;
   logic [RW-1:0]    rank;

   // equal samples rank by lane order, as a stable sort places them
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         if (j == LANE_IDX) begin
            below[j] = 1'b0;
         end else if (j < LANE_IDX) begin
            below[j] = (burst[j] <= burst[LANE_IDX]);
         end else begin
            below[j] = (burst[j] < burst[LANE_IDX]);
         end
      end
      rank = RW'($countones(below));
      keep = (int'(rank) >= TRIM_FIRST) && (int'(rank) < TRIM_END);
   end

endmodule

>>> hdl/abtmf_trim_merge.sv
// ----------------------------------------------------------------------------
// abtmf_trim_merge
// merging stage: adds up the samples the lanes kept, registered
// ----------------------------------------------------------------------------
module abtmf_trim_merge import abtmf_pkg::*; #(
   parameter int LANES = 10,
   parameter int DW    = 12,
   parameter int SUM_W = 15
) (
   input  logic                     clock,
   input  logic [LANES-1:0]         keep,
   input  logic [LANES-1:0][DW-1:0] burst,
   output logic [SUM_W-1:0]         sum_ff
);

   logic [SUM_W-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANES; i++) begin
         if (keep[i]) begin
            sum_in = sum_in + SUM_W'(burst[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

endmodule

>>> hdl/abtmf_const_div.sv
// ----------------------------------------------------------------------------
// abtmf_const_div
// floor division by a fixed divisor: registered reciprocal product, then
// a shift
// ----------------------------------------------------------------------------
module abtmf_const_div import abtmf_pkg::*; #(
   parameter int DIVISOR = 5,
   parameter int IN_W    = 15,
   parameter int OUT_W   = 12
) (
   input  logic             clock,
   input  logic [IN_W-1:0]  in_value,
   output logic [OUT_W-1:0] quotient
);

   localparam int   L_BITS  = $clog2(DIVISOR);
   localparam int   SHIFT   = IN_W + L_BITS;
   localparam int   M_W     = IN_W + 1;
   localparam int   PROD_W  = IN_W + M_W;
   // exact for every IN_W-bit dividend
   localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << SHIFT) / DIVISOR) + 64'd1);

   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;

   assign prod_in  = PROD_W'(in_value) * PROD_W'(RECIP);
   assign quotient = OUT_W'(prod_ff >> SHIFT);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> hdl/adc_burst_trimmed_mean_filter_unit.sv
// ----------------------------------------------------------------------------
// adc_burst_trimmed_mean_filter_unit
// per-channel trimmed-mean ring filter for bursts of adc samples
//
//   channel   dir  port     word
//   --------  ---  -------  ------------------------------------------
//   request   in   req_bus  channel, sample_0 .. sample_9
//   response  out  rsp_bus  out_channel, filtered_value
//
// one burst at a time: a word is taken in idle, and the next one only after
// the steps accept, rank, trim sum, divide by five, ring update, ring
// average divide and output, set by the fixed-divisor units and the ring
// memory's registered read. a stalled response holds the block in its
// output step; the finished word sits in the output register, so the
// response side does not block a new burst once it is loaded.
// reset is synchronous and clears ring valid bits, positions, ring sums and
// smoothed values at once; no clearing pass.
// ----------------------------------------------------------------------------
module adc_burst_trimmed_mean_filter_unit import abtmf_pkg::*; #(
   parameter int CHANNELS     = 9,
   parameter int BURST_LENGTH = 10,
   parameter int RING_DEPTH   = 10,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic        clock,
   input  logic        reset,
   abtmf_req_if.sink   req_bus,
   abtmf_rsp_if.source rsp_bus
);

   // sample width kept internally: a sample field never holds more bits
   localparam int DW        = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int TSW       = DW + $clog2(TRIM_COUNT);
   localparam int RSW       = DW + $clog2(RING_DEPTH);
   localparam int CIW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int MEM_DEPTH = 1 << (CIW + PW);

   // sequencer
   abtmf_state_type state_ff;
   abtmf_state_type state_in;
   logic            ring_we;
   logic            out_load;

   // captured burst and lane results
   logic [CHAN_W-1:0]                        chan_ff;
   logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0]   sample_w;
   logic [BURST_LENGTH-1:0][DW-1:0]          burst_in;
   logic [BURST_LENGTH-1:0][DW-1:0]          burst_ff;
   logic [BURST_LENGTH-1:0]                  lane_keep;
   logic [BURST_LENGTH-1:0]                  keep_ff;
   logic [TSW-1:0]                           trim_sum;
   logic [DW-1:0]                            trim_q;
   logic [DW-1:0]                            avg_q;

   // per-channel state
   logic [PW-1:0]  pos_ff    [CHANNELS];
   logic [RSW-1:0] rsum_ff   [CHANNELS];
   logic [DW-1:0]  smooth_ff [CHANNELS];

   // ring storage, one row of entries per channel
   logic [DW-1:0]          ring_mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]   ring_vld_ff;
   logic [DW-1:0]          old_ff;
   logic                   old_vld_ff;

   // response register
   logic               rsp_valid_ff;
   logic [CHAN_W-1:0]  rsp_chan_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   // selected channel view
   logic                ch_ok;
   logic [CIW-1:0]      chi;
   logic [PW-1:0]       pos_sel;
   logic [PW-1:0]       pos_next;
   logic [RSW-1:0]      rsum_sel;
   logic [RSW-1:0]      rsum_new;
   logic [DW-1:0]       smooth_sel;
   logic [DW-1:0]       old_val;
   logic [CIW+PW-1:0]   ring_addr;
   logic [DW:0]         sm_sum;
   logic [DW-1:0]       sm_new;
   logic                rsp_free;

   // ---------------------------------------------------------------------
   // burst capture, samples masked to the adc width
   // ---------------------------------------------------------------------
   assign sample_w[0] = req_bus.sample_0;
   assign sample_w[1] = req_bus.sample_1;
   assign sample_w[2] = req_bus.sample_2;
   assign sample_w[3] = req_bus.sample_3;
   assign sample_w[4] = req_bus.sample_4;
   assign sample_w[5] = req_bus.sample_5;
   assign sample_w[6] = req_bus.sample_6;
   assign sample_w[7] = req_bus.sample_7;
   assign sample_w[8] = req_bus.sample_8;
   assign sample_w[9] = req_bus.sample_9;

   always_comb begin
      for (int i = 0; i < BURST_LENGTH; i++) begin
         burst_in[i] = sample_w[i][DW-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // rank lanes and merge: the sorted positions in the trim window are
   // exactly the samples whose rank lands there
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < BURST_LENGTH; g++) begin : g_lane
      abtmf_rank_lane #(
         .LANES    (BURST_LENGTH),
         .LANE_IDX (g),
         .DW       (DW)
      ) u_lane (
         .burst (burst_ff),
         .keep  (lane_keep[g])
      );
   end

   abtmf_trim_merge #(
      .LANES (BURST_LENGTH),
      .DW    (DW),
      .SUM_W (TSW)
   ) u_merge (
      .clock  (clock),
      .keep   (keep_ff),
      .burst  (burst_ff),
      .sum_ff (trim_sum)
   );

   // trimmed mean: floor of the kept sum over five
   abtmf_const_div #(
      .DIVISOR (TRIM_COUNT),
      .IN_W    (TSW),
      .OUT_W   (DW)
   ) u_trim_div (
      .clock    (clock),
      .in_value (trim_sum),
      .quotient (trim_q)
   );

   // ring average: floor of the running ring sum over the ring depth
   abtmf_const_div #(
      .DIVISOR (RING_DEPTH),
      .IN_W    (RSW),
      .OUT_W   (DW)
   ) u_avg_div (
      .clock    (clock),
      .in_value (rsum_sel),
      .quotient (avg_q)
   );

   // ---------------------------------------------------------------------
   // channel view; an unknown channel touches no state and answers zero
   // ---------------------------------------------------------------------
   assign ch_ok      = ({1'b0, chan_ff} < (CHAN_W + 1)'(CHANNELS));
   assign chi        = chan_ff[CIW-1:0];
   assign pos_sel    = ch_ok ? pos_ff[chi] : '0;
   assign rsum_sel   = ch_ok ? rsum_ff[chi] : '0;
   assign smooth_sel = ch_ok ? smooth_ff[chi] : '0;
   assign ring_addr  = {chi, pos_sel};
   assign pos_next   = (pos_sel == PW'(RING_DEPTH - 1)) ? '0 : pos_sel + 1'b1;

   // entries never written since reset count as zero
   assign old_val  = old_vld_ff ? old_ff : '0;
   // running sum stays equal to the sum of the ring
   assign rsum_new = rsum_sel - RSW'(old_val) + RSW'(trim_q);

   // half-and-half blend, truncating
   assign sm_sum   = {1'b0, smooth_sel} + {1'b0, avg_q};
   assign sm_new   = sm_sum[DW:1];

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      ring_we       = 1'b0;
      out_load      = 1'b0;
      req_bus.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               state_in = ST_RANK;
            end
         end
         ST_RANK: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_TRIM_DIV;
         end
         ST_TRIM_DIV: begin
            state_in = ST_RING;
         end
         ST_RING: begin
            ring_we  = ch_ok;
            state_in = ST_AVG_DIV;
         end
         ST_AVG_DIV: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and per-channel registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ring_vld_ff  <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c]    <= '0;
            rsum_ff[c]   <= '0;
            smooth_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ring_we) begin
            ring_vld_ff[ring_addr] <= 1'b1;
            pos_ff[chi]            <= pos_next;
            rsum_ff[chi]           <= rsum_new;
         end
         if (out_load && ch_ok) begin
            smooth_ff[chi] <= sm_new;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         chan_ff  <= req_bus.channel;
         burst_ff <= burst_in;
      end
      keep_ff <= lane_keep;
      if (out_load) begin
         rsp_chan_ff  <= chan_ff;
         rsp_value_ff <= ch_ok ? VALUE_W'(sm_new) : '0;
      end
   end

   // ring memory, read address held from rank through ring update
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_addr] <= trim_q;
      end
      old_ff     <= ring_mem[ring_addr];
      old_vld_ff <= ring_vld_ff[ring_addr];
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.out_channel    = rsp_chan_ff;
   assign rsp_bus.filtered_value = rsp_value_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
`ifndef ASSERT_OFF
   a_accept_starts_rank: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_RANK))
      else $error("accepted burst did not start ranking");

   a_rsp_from_out_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output step");

   a_ring_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      ch_ok |-> (int'(pos_sel) < RING_DEPTH))
      else $error("ring position beyond ring depth");
`endif

endmodule

>>> sim/abtmf_filter_monitor.sv
// ----------------------------------------------------------------------------
// abtmf_filter_monitor
// watches the burst and result channels of the trimmed-mean filter, keeps
// its own per-channel ring and smoothed state, predicts each filtered word
// and compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module abtmf_filter_monitor import abtmf_pkg::*; (
   input  logic clock,
   input  logic reset,
   abtmf_req_if req_bus,
   abtmf_rsp_if rsp_bus,
   output int   mismatches,
   output int   pending_words
);

   localparam int NUM_CHANNELS = 9;
   localparam int RING_LEN     = 10;

   typedef logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] burst_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  out_channel;
      logic [VALUE_W-1:0] filtered_value;
   } filtered_word_type;

   logic [SAMPLE_W-1:0] mean_ring [NUM_CHANNELS][RING_LEN];
   logic [3:0]          ring_slot [NUM_CHANNELS];
   logic [VALUE_W-1:0]  smoothed  [NUM_CHANNELS];

   filtered_word_type expected_filtered [$];

   initial begin
      mismatches    = 0;
      pending_words = 0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   // sort, trim to positions 3..7, push into the ring, blend with the old value
   function automatic logic [VALUE_W-1:0] advance_channel(input logic [CHAN_W-1:0] ch,
                                                          input burst_type raw);
      int sorted [SAMPLE_FIELDS];
      int key;
      int j;
      int trim_sum;
      int ring_sum;
      int ring_avg;
      int slot;
      if (ch >= NUM_CHANNELS) return '0;
      for (int i = 0; i < SAMPLE_FIELDS; i++) sorted[i] = int'(raw[i]);
      for (int i = 1; i < SAMPLE_FIELDS; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      trim_sum = 0;
      for (int i = TRIM_FIRST; i < TRIM_END; i++) trim_sum += sorted[i];
      slot = int'(ring_slot[ch]);
      if (slot >= RING_LEN) slot = 0;
      mean_ring[ch][slot] = SAMPLE_W'(trim_sum / TRIM_COUNT);
      ring_slot[ch] = (slot + 1 >= RING_LEN) ? 4'd0 : 4'(slot + 1);
      ring_sum = 0;
      for (int i = 0; i < RING_LEN; i++) ring_sum += int'(mean_ring[ch][i]);
      ring_avg = ring_sum / RING_LEN;
      smoothed[ch] = VALUE_W'((int'(smoothed[ch]) + ring_avg) >> 1);
      return smoothed[ch];
   endfunction

   always @(posedge clock) begin
      filtered_word_type want;
      filtered_word_type got;
      burst_type         raw;
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            ring_slot[c] = '0;
            smoothed[c]  = '0;
            for (int i = 0; i < RING_LEN; i++) mean_ring[c][i] = '0;
         end
         expected_filtered.delete();
      end else begin
         // results first: a word leaving now belongs to an earlier burst
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.out_channel    = rsp_bus.out_channel;
            got.filtered_value = rsp_bus.filtered_value;
            if (expected_filtered.size() == 0) begin
               report_mismatch($sformatf("word with nothing pending: channel %0d value %0d",
                                         got.out_channel, got.filtered_value));
            end else begin
               want = expected_filtered.pop_front();
               if (got.out_channel !== want.out_channel)
                  report_mismatch($sformatf("out_channel %0d, expected %0d",
                                            got.out_channel, want.out_channel));
               if (got.filtered_value !== want.filtered_value)
                  report_mismatch($sformatf("filtered_value %0d, expected %0d (channel %0d)",
                                            got.filtered_value, want.filtered_value,
                                            want.out_channel));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            raw = {req_bus.sample_9, req_bus.sample_8, req_bus.sample_7, req_bus.sample_6,
                   req_bus.sample_5, req_bus.sample_4, req_bus.sample_3, req_bus.sample_2,
                   req_bus.sample_1, req_bus.sample_0};
            want.out_channel    = req_bus.channel;
            want.filtered_value = advance_channel(req_bus.channel, raw);
            expected_filtered.push_back(want);
         end
      end
      pending_words = expected_filtered.size();
   end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for adc_burst_trimmed_mean_filter_unit: directed
// bursts at the sample and channel extremes, then random bursts with idle
// bursts on both channels, a long response hold-off, a drain pause and a
// final stretch at full rate; a monitor beside the block does the checking
// ----------------------------------------------------------------------------
module testbench;
   import abtmf_pkg::*;

   localparam int RESET_CYCLES = 10;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
   localparam int HOLD_CYCLES  = 200;      // long response hold-off
   localparam int TAIL_CYCLES  = 30;       // settling time after the drain
   localparam int CYCLE_LIMIT  = 300000;   // overall run limit

   typedef logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] burst_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   mismatch_count;
   int   pending_words;

   // idling switches set by the sender, read by the sender and the receiver
   bit   req_idling   = 1'b0;
   bit   rsp_idling   = 1'b0;
   bit   hold_request = 1'b0;

   abtmf_req_if req_bus ();
   abtmf_rsp_if rsp_bus ();

   adc_burst_trimmed_mean_filter_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   abtmf_filter_monitor monitor (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .mismatches    (mismatch_count),
      .pending_words (pending_words)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // run limit, counted in clock cycles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** adc_burst_trimmed_mean_filter_unit: FAILED **");
         $finish;
      end
   end

   // put one burst word on the request payload
   task automatic put_fields(input logic [CHAN_W-1:0] ch, input burst_type b);
      req_bus.channel  <= ch;
      req_bus.sample_0 <= b[0];
      req_bus.sample_1 <= b[1];
      req_bus.sample_2 <= b[2];
      req_bus.sample_3 <= b[3];
      req_bus.sample_4 <= b[4];
      req_bus.sample_5 <= b[5];
      req_bus.sample_6 <= b[6];
      req_bus.sample_7 <= b[7];
      req_bus.sample_8 <= b[8];
      req_bus.sample_9 <= b[9];
   endtask

   // offer one word, hold it until accepted, then maybe idle for a burst
   task automatic offer_burst(input logic [CHAN_W-1:0] ch, input burst_type b);
      req_bus.valid <= 1'b1;
      put_fields(ch, b);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // accepted at this edge; valid stays up if the next word follows at once
      if (req_idling && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   function automatic burst_type random_burst();
      burst_type b;
      int        base;
      int        v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            // uniform noise over the full code range
            for (int i = 0; i < SAMPLE_FIELDS; i++) b[i] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
         end
         4, 5, 6, 7: begin
            // a steady reading with jitter and the odd rail spike
            base = $urandom_range(0, SAMPLE_MAX);
            for (int i = 0; i < SAMPLE_FIELDS; i++) begin
               v = base + int'($urandom_range(0, 80)) - 40;
               if (v < 0) v = 0;
               if (v > SAMPLE_MAX) v = SAMPLE_MAX;
               if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
               b[i] = SAMPLE_W'(v);
            end
         end
         8: begin
            for (int i = 0; i < SAMPLE_FIELDS; i++)
               b[i] = SAMPLE_W'($urandom_range(0, 1) ? SAMPLE_MAX : 0);
         end
         default: begin
            // every sample the same
            v = $urandom_range(0, SAMPLE_MAX);
            for (int i = 0; i < SAMPLE_FIELDS; i++) b[i] = SAMPLE_W'(v);
         end
      endcase
      return b;
   endfunction

   // mostly valid channels, now and then an invalid one from 9 to 15
   function automatic logic [CHAN_W-1:0] random_channel();
      if ($urandom_range(0, 11) == 0) return CHAN_W'($urandom_range(9, 15));
      return CHAN_W'($urandom_range(0, 8));
   endfunction

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) offer_burst(random_channel(), random_burst());
   endtask

   // receiver: idle bursts, a long hold-off on request, otherwise ready
   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // sender and verdict
   initial begin
      burst_type b;
      req_bus.valid <= 1'b0;
      put_fields('0, '0);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idling = 1'b1;
      rsp_idling = 1'b1;

      // directed: rails, out-of-range channels, ordering, trim window, ring wrap
      offer_burst(4'd0, '0);
      for (int i = 0; i < SAMPLE_FIELDS; i++) b[i] = SAMPLE_W'(SAMPLE_MAX);
      offer_burst(4'd0, b);
      offer_burst(4'd8, b);
      for (int i = 0; i < SAMPLE_FIELDS; i++) b[i] = SAMPLE_W'((i % 2) ? SAMPLE_MAX : 0);
      offer_burst(4'd8, b);
      // channels past the last one leave every state alone and give zero
      offer_burst(4'd9, random_burst());
      for (int i = 0; i < SAMPLE_FIELDS; i++) b[i] = SAMPLE_W'(SAMPLE_MAX);
      offer_burst(4'd15, b);
      // already sorted, then reversed
      for (int i = 0; i < SAMPLE_FIELDS; i++) b[i] = SAMPLE_W'(i * 455);
      offer_burst(4'd2, b);
      for (int i = 0; i < SAMPLE_FIELDS; i++) b[i] = SAMPLE_W'((SAMPLE_FIELDS - 1 - i) * 455);
      offer_burst(4'd2, b);
      // outliers at both ends must fall outside the trim window
      for (int i = 0; i < SAMPLE_FIELDS; i++) b[i] = 12'd2048;
      b[1] = 12'd0;
      b[6] = SAMPLE_W'(SAMPLE_MAX);
      b[9] = 12'd0;
      offer_burst(4'd4, b);
      // half at each rail: window straddles the split
      for (int i = 0; i < SAMPLE_FIELDS; i++) b[i] = SAMPLE_W'((i < 5) ? SAMPLE_MAX : 0);
      offer_burst(4'd4, b);
      // twelve bursts on one channel walk the ring past its wrap
      for (int n = 0; n < 12; n++) offer_burst(4'd5, random_burst());

      // random with idling on both sides
      run_random(500);

      // receiver stalls for a long stretch while words keep coming
      req_idling   = 1'b0;
      hold_request = 1'b1;
      run_random(30);
      req_idling = 1'b1;

      // sender waits for the block to drain completely
      req_bus.valid <= 1'b0;
      while (pending_words != 0) @(posedge clock);

      run_random(470);

      // final stretch at full rate on both sides
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      run_random(300);
      req_bus.valid <= 1'b0;

      while (pending_words != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** adc_burst_trimmed_mean_filter_unit: PASSED **");
      end else begin
         $display("** adc_burst_trimmed_mean_filter_unit: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/abtmf_pkg.sv
hdl/abtmf_ifs.sv
hdl/abtmf_rank_lane.sv
hdl/abtmf_trim_merge.sv
hdl/abtmf_const_div.sv
hdl/adc_burst_trimmed_mean_filter_unit.sv
sim/abtmf_filter_monitor.sv
sim/testbench.sv
